// ===== design/sqlss_pkg.sv =====
package sqlss_pkg;

    localparam int MAX_TAG = 64;
    localparam int TAG_AW  = $clog2(MAX_TAG);
    localparam int TAG_LW  = $clog2(MAX_TAG + 2);

    localparam logic [TAG_LW-1:0] TAG_ONE      = TAG_LW'(1);
    localparam logic [TAG_LW-1:0] TAG_FULL_LEN = TAG_LW'(MAX_TAG);
    localparam logic [TAG_LW-1:0] TAG_OVF_LEN  = TAG_LW'(MAX_TAG + 1);

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [3:0] {
        Q_NONE   = 4'b0001,
        Q_SINGLE = 4'b0010,
        Q_DOUBLE = 4'b0100,
        Q_DOLLAR = 4'b1000
    } quote_t;

    typedef enum logic [2:0] {
        C_NONE  = 3'b001,
        C_LINE  = 3'b010,
        C_BLOCK = 3'b100
    } comment_t;

    typedef enum logic [3:0] {
        SK_ALL        = 4'b0001,
        SK_FROM_END   = 4'b0010,
        SK_NONE       = 4'b0100,
        SK_FROM_START = 4'b1000
    } skip_t;

    typedef logic [MAX_TAG-1:0][7:0] tag_arr_t;

    typedef struct packed {
        quote_t              quote;
        comment_t            comment;
        skip_t               skip;
        logic                dstart;
        logic [TAG_LW-1:0]   tag_len;
        logic [MAX_TAG-1:0]  dmatch;
        logic                at_start;
        logic                ovf;
    } ctx_t;

    typedef struct packed {
        ctx_t               nxt;
        logic               emit;
        logic               stmt_end;
        logic               ovf;
        logic               tag_we;
        logic [TAG_AW-1:0]  tag_addr;
        logic [7:0]         tag_data;
    } proc_res_t;

    typedef struct packed {
        logic [7:0] stmt_byte;
        logic       stmt_end;
        logic       tag_overflow;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [1:0] cnt;
        out_item_t  r0;
        out_item_t  r1;
    } batch_t;

    function automatic logic is_ws(logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic ctx_t ctx_reset();
        ctx_t t;
        t.quote    = Q_NONE;
        t.comment  = C_NONE;
        t.skip     = SK_ALL;
        t.dstart   = 1'b0;
        t.tag_len  = '0;
        t.dmatch   = '0;
        t.at_start = 1'b1;
        t.ovf      = 1'b0;
        return t;
    endfunction

    function automatic tag_arr_t tag_write(tag_arr_t tag, logic we, logic [TAG_AW-1:0] addr,
                                           logic [7:0] data);
        tag_arr_t t;
        t = tag;
        if (we) begin
            t[addr] = data;
        end
        return t;
    endfunction

    // One character of the splitter with its one-byte lookahead. The dollar
    // close search keeps one bit per tag prefix that matches the recent text.
    function automatic proc_res_t sqlss_proc(ctx_t s, tag_arr_t tag, logic [7:0] c,
                                             logic [7:0] n, logic last);
        proc_res_t          r;
        ctx_t               t;
        skip_t              ph;
        logic               was;
        logic               done;
        logic               opened;
        logic [MAX_TAG-1:0] dn;
        logic [TAG_LW-1:0]  lm1;
        r          = '0;
        r.nxt      = s;
        r.tag_data = c;
        t          = s;
        ph         = s.skip;
        was        = s.dstart;
        done       = 1'b0;
        opened     = 1'b0;
        dn         = '0;
        lm1        = '0;
        if (!(s.at_start && is_ws(c))) begin
            t.skip = SK_ALL;
            if (ph == SK_ALL && s.comment == C_NONE) begin
                if (c == CH_SQUOTE) begin
                    if (t.quote == Q_NONE) begin
                        t.quote  = Q_SINGLE;
                        t.dstart = 1'b0;
                    end else if (t.quote == Q_SINGLE) begin
                        t.quote = Q_NONE;
                    end
                end else if (c == CH_DQUOTE) begin
                    if (t.quote == Q_NONE) begin
                        t.quote  = Q_DOUBLE;
                        t.dstart = 1'b0;
                    end else if (t.quote == Q_DOUBLE) begin
                        t.quote = Q_NONE;
                    end
                end else if (c == CH_DOLLAR && t.quote == Q_NONE) begin
                    if (!t.dstart) begin
                        r.tag_we   = 1'b1;
                        r.tag_addr = '0;
                        r.tag_data = CH_DOLLAR;
                        t.tag_len  = TAG_ONE;
                        t.dstart   = 1'b1;
                    end else begin
                        if (t.tag_len > TAG_FULL_LEN) begin
                            t.ovf     = 1'b1;
                            t.tag_len = TAG_FULL_LEN;
                        end
                        t.quote  = Q_DOLLAR;
                        t.dmatch = '0;
                        t.dstart = 1'b0;
                        opened   = 1'b1;
                    end
                end
                if (t.quote == Q_DOLLAR && !opened) begin
                    dn[0] = (tag[0] == c);
                    for (int j = 1; j < MAX_TAG; j++) begin
                        dn[j] = t.dmatch[j-1] & (tag[j] == c);
                    end
                    lm1 = t.tag_len - TAG_ONE;
                    if (dn[lm1[TAG_AW-1:0]]) begin
                        t.quote  = Q_NONE;
                        t.skip   = SK_FROM_START;
                        t.dmatch = '0;
                        done     = 1'b1;
                    end else begin
                        t.dmatch = dn;
                    end
                end
            end
            if (was && t.dstart) begin
                if (t.tag_len < TAG_FULL_LEN) begin
                    r.tag_we   = 1'b1;
                    r.tag_addr = t.tag_len[TAG_AW-1:0];
                    r.tag_data = c;
                    t.tag_len  = t.tag_len + TAG_ONE;
                end else begin
                    t.tag_len = TAG_OVF_LEN;
                end
            end
            if (!done && (ph == SK_ALL || ph == SK_FROM_START) &&
                t.comment == C_NONE && t.quote == Q_NONE) begin
                if (c == CH_SLASH && n == CH_STAR) begin
                    t.comment = C_BLOCK;
                    t.skip    = SK_FROM_END;
                    done      = 1'b1;
                end else if (c == CH_DASH && n == CH_DASH) begin
                    t.comment = C_LINE;
                    t.skip    = SK_FROM_END;
                    done      = 1'b1;
                end
            end
            if (!done && ph != SK_NONE && t.comment == C_BLOCK && c == CH_STAR &&
                n == CH_SLASH) begin
                t.comment = C_NONE;
                t.skip    = SK_NONE;
                done      = 1'b1;
            end
            if (!done && t.comment == C_LINE && c == CH_NL) begin
                t.comment = C_NONE;
            end
            if (!done && t.quote == Q_NONE && t.comment == C_NONE && c == CH_SEMI) begin
                t = ctx_reset();
            end else begin
                t.at_start = 1'b0;
                r.emit     = 1'b1;
                r.stmt_end = last || (n == CH_SEMI && t.quote == Q_NONE &&
                                      t.comment == C_NONE);
                r.ovf      = t.ovf;
            end
            r.nxt = t;
        end
        return r;
    endfunction

endpackage

// ===== design/sqlss_core.sv =====
module sqlss_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              go,
    input  logic [7:0]        text_byte,
    input  logic              end_of_text,
    output sqlss_pkg::batch_t batch
);
    import sqlss_pkg::*;

    ctx_t      ctx_reg, ctx_next;
    tag_arr_t  tag_reg, tag_next;
    tag_arr_t  tag_mid;
    logic [7:0] held_byte_reg, held_byte_next;
    logic      held_valid_reg, held_valid_next;
    proc_res_t p1, p2;
    out_item_t i1, i2;
    logic      use2;

    always_comb begin
        p1     = '0;
        p1.nxt = ctx_reg;
        if (held_valid_reg) begin
            p1 = sqlss_proc(ctx_reg, tag_reg, held_byte_reg, text_byte, 1'b0);
        end
        tag_mid = tag_write(tag_reg, p1.tag_we, p1.tag_addr, p1.tag_data);
        p2      = sqlss_proc(p1.nxt, tag_mid, text_byte, CH_NUL, 1'b1);

        ctx_next        = ctx_reg;
        tag_next        = tag_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        if (go) begin
            tag_next = tag_mid;
            if (end_of_text) begin
                ctx_next        = ctx_reset();
                held_byte_next  = '0;
                held_valid_next = 1'b0;
            end else begin
                ctx_next        = p1.nxt;
                held_byte_next  = text_byte;
                held_valid_next = 1'b1;
            end
        end

        use2 = end_of_text && p2.emit;
        i1   = '{stmt_byte: held_byte_reg, stmt_end: p1.stmt_end,
                 tag_overflow: p1.ovf, last_of_run: !use2};
        i2   = '{stmt_byte: text_byte, stmt_end: p2.stmt_end,
                 tag_overflow: p2.ovf, last_of_run: 1'b1};
        batch = '0;
        if (p1.emit) begin
            batch.r0  = i1;
            batch.r1  = i2;
            batch.cnt = use2 ? 2'd2 : 2'd1;
        end else begin
            batch.r0  = i2;
            batch.r1  = i2;
            batch.cnt = use2 ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg        <= ctx_reset();
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
        end else begin
            ctx_reg        <= ctx_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg <= tag_next;
    end

endmodule

// ===== design/sqlss_outbuf.sv =====
module sqlss_outbuf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  sqlss_pkg::batch_t    batch,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output sqlss_pkg::out_item_t head,
    output logic                 room
);
    import sqlss_pkg::*;

    out_item_t  s0_reg, s0_next;
    out_item_t  s1_reg, s1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign head     = s0_reg;
    assign pop      = m_tvalid && m_tready;
    assign room     = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);

    always_comb begin
        s0_next  = s0_reg;
        s1_next  = s1_reg;
        cnt_next = cnt_reg;
        if (load) begin
            s0_next  = batch.r0;
            s1_next  = batch.r1;
            cnt_next = batch.cnt;
        end else if (pop) begin
            s0_next  = s1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        s0_reg <= s0_next;
        s1_reg <= s1_next;
    end

endmodule

// ===== design/sql_statement_splitter.sv =====
// Channel | Dir | tdata              | tlast        | tuser
// s_      | in  | [7:0] text_byte    | end_of_text  | -
// m_      | out | [7:0] stmt_byte    | stmt_end     | [0] tag_overflow, [1] last_of_run
//
// A word is taken into the input register and resolved once the result register has room,
// so one input word per cycle is sustained when each word gives at most one result and
// m_ does not stall. The final word of a text can give two results; the next word then
// waits and is resolved as the second of them leaves the two-slot result register.
// Reset is synchronous and active low and returns the block to the start of a statement.
// A stall on m_ holds the result register and, through it, the input register.
module sql_statement_splitter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] stmt_byte
    output logic       m_tlast,
    output logic [1:0] m_tuser    // [0] tag_overflow, [1] last_of_run
);
    import sqlss_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       in_eot_reg, in_eot_next;
    logic       room;
    logic       go;
    batch_t     batch;
    out_item_t  head;

    assign go       = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_eot_next   = in_eot_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_byte_next  = s_tdata;
            in_eot_next   = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        in_eot_reg  <= in_eot_next;
    end

    sqlss_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .go          (go),
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .batch       (batch)
    );

    sqlss_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (go),
        .batch    (batch),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .head     (head),
        .room     (room)
    );

    assign m_tdata = head.stmt_byte;
    assign m_tlast = head.stmt_end;
    assign m_tuser = {head.last_of_run, head.tag_overflow};

    a_empty_takes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while no result is pending");

    a_two_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && batch.cnt == 2'd2) |-> in_eot_reg)
        else $error("two results from a word that does not end the text");

    a_run_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        go |-> ((batch.cnt == 2'd1 && batch.r0.last_of_run) ||
                (batch.cnt == 2'd2 && !batch.r0.last_of_run && batch.r1.last_of_run) ||
                (batch.cnt == 2'd0)))
        else $error("last result of a word is not marked");

endmodule

// ===== sim/sql_statement_splitter_tb.sv =====
`timescale 1ns / 100ps

module sql_statement_splitter_tb;

    import sqlss_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } text_word_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;   // [7:0] text_byte
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [7:0] stmt_byte
    logic       m_tlast;
    logic [1:0] m_tuser;         // [0] tag_overflow, [1] last_of_run

    sql_statement_splitter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Splitter state as the predictor sees it.
    logic [7:0]  la_byte;
    bit          la_valid;
    quote_t      quote;
    comment_t    cmt;
    skip_t       skip_mode;
    bit          tag_open;
    logic [7:0]  tag_mem [MAX_TAG];
    int unsigned tag_len;
    int unsigned tag_pos;
    bit          at_start;
    bit          tag_ovf;

    out_item_t   stmt_words_due[$];
    text_word_t  text_words[$];
    logic [7:0]  draft[$];

    int errors      = 0;
    int texts       = 0;
    int n_directed  = 0;
    int words_in    = 0;
    int words_out   = 0;
    int stmt_ends   = 0;
    int ovf_words   = 0;
    int holds       = 0;
    bit long_done   = 0;
    int send_gap    = 0;
    bit send_calm   = 0;
    int recv_gap    = 0;
    bit recv_calm   = 0;
    int hold_seen   = 0;
    int hold_left   = 0;

    function automatic void stmt_reset();
        quote     = Q_NONE;
        cmt       = C_NONE;
        skip_mode = SK_ALL;
        tag_open  = 0;
        tag_len   = 0;
        tag_pos   = 0;
        at_start  = 1;
        tag_ovf   = 0;
    endfunction

    // Advances the search for the closing tag; the earliest occurrence wins.
    function automatic bit tag_match_step(logic [7:0] c);
        int unsigned m;
        int          k;
        bit          same;
        m = tag_pos;
        if (m < tag_len && tag_mem[m] == c) begin
            m++;
            if (m >= tag_len) begin
                tag_pos = 0;
                return 1;
            end
            tag_pos = m;
            return 0;
        end
        for (k = m; k >= 1; k--) begin
            if (tag_mem[k-1] == c) begin
                same = 1;
                for (int i = 0; i < k - 1; i++) begin
                    if (tag_mem[i] != tag_mem[m - k + 1 + i]) begin
                        same = 0;
                    end
                end
                if (same) begin
                    tag_pos = k;
                    return 0;
                end
            end
        end
        tag_pos = 0;
        return 0;
    endfunction

    function automatic bit split_byte(input logic [7:0] c, input logic [7:0] n, input bit fin,
                                      output out_item_t o);
        skip_t ph;
        bit    was_open;
        bit    done;
        bit    opened;
        o      = '0;
        done   = 0;
        opened = 0;
        if (at_start && (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))) begin
            return 0;
        end
        ph        = skip_mode;
        skip_mode = SK_ALL;
        was_open  = tag_open;
        if (ph == SK_ALL && cmt == C_NONE) begin
            if (c == CH_SQUOTE) begin
                if (quote == Q_NONE) begin
                    quote    = Q_SINGLE;
                    tag_open = 0;
                end else if (quote == Q_SINGLE) begin
                    quote = Q_NONE;
                end
            end else if (c == CH_DQUOTE) begin
                if (quote == Q_NONE) begin
                    quote    = Q_DOUBLE;
                    tag_open = 0;
                end else if (quote == Q_DOUBLE) begin
                    quote = Q_NONE;
                end
            end else if (c == CH_DOLLAR && quote == Q_NONE) begin
                if (!tag_open) begin
                    tag_mem[0] = CH_DOLLAR;
                    tag_len    = 1;
                    tag_open   = 1;
                end else begin
                    if (tag_len > MAX_TAG) begin
                        tag_ovf = 1;
                        tag_len = MAX_TAG;
                    end
                    quote    = Q_DOLLAR;
                    tag_pos  = 0;
                    tag_open = 0;
                    opened   = 1;
                end
            end
            if (quote == Q_DOLLAR && !opened) begin
                if (tag_match_step(c)) begin
                    quote     = Q_NONE;
                    skip_mode = SK_FROM_START;
                    done      = 1;
                end
            end
        end
        if (was_open && tag_open) begin
            if (tag_len < MAX_TAG) begin
                tag_mem[tag_len] = c;
                tag_len++;
            end else begin
                tag_len = MAX_TAG + 1;
            end
        end
        if (!done && (ph == SK_ALL || ph == SK_FROM_START) && cmt == C_NONE &&
            quote == Q_NONE) begin
            if (c == CH_SLASH && n == CH_STAR) begin
                cmt       = C_BLOCK;
                skip_mode = SK_FROM_END;
                done      = 1;
            end else if (c == CH_DASH && n == CH_DASH) begin
                cmt       = C_LINE;
                skip_mode = SK_FROM_END;
                done      = 1;
            end
        end
        if (!done && ph != SK_NONE && cmt == C_BLOCK && c == CH_STAR && n == CH_SLASH) begin
            cmt       = C_NONE;
            skip_mode = SK_NONE;
            done      = 1;
        end
        if (!done && cmt == C_LINE && c == CH_NL) begin
            cmt = C_NONE;
        end
        if (!done && quote == Q_NONE && cmt == C_NONE && c == CH_SEMI) begin
            stmt_reset();
            return 0;
        end
        at_start       = 0;
        o.stmt_byte    = c;
        o.stmt_end     = fin || (n == CH_SEMI && quote == Q_NONE && cmt == C_NONE);
        o.tag_overflow = tag_ovf;
        return 1;
    endfunction

    function automatic void feed_text_word(logic [7:0] c, bit fin);
        out_item_t r [2];
        out_item_t o;
        int        cnt;
        cnt = 0;
        if (la_valid) begin
            if (split_byte(la_byte, c, 0, o)) begin
                r[cnt] = o;
                cnt++;
            end
        end
        if (fin) begin
            if (split_byte(c, CH_NUL, 1, o)) begin
                r[cnt] = o;
                cnt++;
            end
            la_byte  = '0;
            la_valid = 0;
            stmt_reset();
        end else begin
            la_byte  = c;
            la_valid = 1;
        end
        if (cnt > 0) begin
            r[cnt-1].last_of_run = 1'b1;
        end
        for (int i = 0; i < cnt; i++) begin
            stmt_words_due.push_back(r[i]);
        end
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            draft.push_back(s[i]);
        end
    endfunction

    function automatic void add_pick(string alpha, int cnt);
        for (int i = 0; i < cnt; i++) begin
            draft.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
        end
    endfunction

    function automatic void add_noise(int cnt);
        for (int i = 0; i < cnt; i++) begin
            draft.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void add_space(int cnt);
        for (int i = 0; i < cnt; i++) begin
            if ($urandom_range(0, 5) == 5) begin
                draft.push_back(8'h20);
            end else begin
                draft.push_back(8'(9 + $urandom_range(0, 4)));
            end
        end
    endfunction

    function automatic void flush_text();
        text_word_t w;
        for (int i = 0; i < draft.size(); i++) begin
            w.ch  = draft[i];
            w.eot = (i == draft.size() - 1);
            text_words.push_back(w);
        end
        draft.delete();
        texts++;
    endfunction

    // Mostly short tags; now and then one near or past the tag store size.
    function automatic void add_dollar_quote();
        string tag;
        int    k;
        if (!long_done || $urandom_range(0, 24) == 0) begin
            k         = $urandom_range(60, 70);
            long_done = 1;
        end else begin
            k = $urandom_range(0, 3);
        end
        tag = "$";
        for (int i = 0; i < k; i++) begin
            tag = {tag, ($urandom_range(0, 1) != 0) ? "a" : "b"};
        end
        tag = {tag, "$"};
        add_str(tag);
        add_pick("ab$; x'\"", $urandom_range(0, 8));
        if ($urandom_range(0, 2) == 0) begin
            add_str(tag.substr(0, tag.len() / 2));
            add_pick("ab$;", $urandom_range(0, 3));
        end
        add_str(tag);
    endfunction

    function automatic void add_fragment();
        case ($urandom_range(0, 9))
            0, 1: begin
                add_pick("selct abz01_,()=*+/-.$", $urandom_range(1, 6));
            end
            2: begin
                add_str("'");
                add_pick("ab ;\"$-/*", $urandom_range(0, 6));
                add_str("'");
            end
            3: begin
                add_str("\"");
                add_pick("ab ;'$-/*", $urandom_range(0, 6));
                add_str("\"");
            end
            4, 5: begin
                add_dollar_quote();
            end
            6: begin
                add_str("--");
                add_pick("ab ;'\"$*/-", $urandom_range(0, 6));
                add_str("\n");
            end
            7: begin
                add_str("/*");
                add_pick("ab ;'\"$*/-\n", $urandom_range(0, 6));
                add_str("*/");
            end
            8: begin
                add_noise($urandom_range(1, 3));
            end
            default: begin
                add_space($urandom_range(1, 3));
            end
        endcase
    endfunction

    function automatic void add_random_text();
        int nst;
        if ($urandom_range(0, 11) == 0) begin
            add_noise($urandom_range(1, 12));
            flush_text();
            return;
        end
        nst = $urandom_range(1, 4);
        for (int s = 0; s < nst; s++) begin
            if ($urandom_range(0, 2) == 0) begin
                add_space($urandom_range(1, 3));
            end
            for (int f = $urandom_range(1, 5); f > 0; f--) begin
                add_fragment();
            end
            if (s < nst - 1 || $urandom_range(0, 1) != 0) begin
                add_str(";");
                if ($urandom_range(0, 5) == 0) begin
                    add_str(" ;");
                end
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 4))
                0: add_str("'");
                1: add_str("\"");
                2: add_str("$x$");
                3: add_str("/*");
                default: add_str("--");
            endcase
            add_pick("ab;", $urandom_range(0, 3));
        end
        flush_text();
    endfunction

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        text_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                feed_text_word(s_tdata, s_tlast);
                words_in++;
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (text_words.size() != 0) begin
                w = text_words.pop_front();
                s_tdata  <= w.ch;
                s_tlast  <= w.eot;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 63) == 0) begin
                    send_calm = !send_calm;
                end
                send_gap = send_calm ? 0 : $urandom_range(0, 6);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long output stalls while the input side keeps offering words.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_seen = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                hold_seen++;
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (s_tvalid && s_tready && (hold_seen == 400 || hold_seen == 1400)) begin
                hold_left <= 150;
                holds++;
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_out++;
                if (stmt_words_due.size() == 0) begin
                    errors++;
                    if (errors <= 30) begin
                        $display("%0t ns: unexpected statement word: expected none, got byte %h end %b tuser %b",
                                 $time, m_tdata, m_tlast, m_tuser);
                    end
                end else begin
                    want = stmt_words_due.pop_front();
                    if (m_tdata !== want.stmt_byte || m_tlast !== want.stmt_end ||
                        m_tuser !== {want.last_of_run, want.tag_overflow}) begin
                        errors++;
                        if (errors <= 30) begin
                            $display("%0t ns: mismatch: expected byte %h end %b tuser %b, got byte %h end %b tuser %b",
                                     $time, want.stmt_byte, want.stmt_end,
                                     {want.last_of_run, want.tag_overflow},
                                     m_tdata, m_tlast, m_tuser);
                        end
                    end
                    if (want.stmt_end) begin
                        stmt_ends++;
                    end
                    if (want.tag_overflow) begin
                        ovf_words++;
                    end
                end
                if ($urandom_range(0, 63) == 0) begin
                    recv_calm = !recv_calm;
                end
                recv_gap = recv_calm ? 0 : $urandom_range(0, 6);
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #4000000;
        $display("** sql_statement_splitter: FAILED **");
        $finish;
    end

    initial begin
        la_byte  = '0;
        la_valid = 0;
        for (int i = 0; i < MAX_TAG; i++) begin
            tag_mem[i] = '0;
        end
        stmt_reset();

        add_str(" ;;a;");
        flush_text();
        add_str("x");
        draft.push_back(CH_NUL);
        draft.push_back(8'hFF);
        draft.push_back(8'h80);
        add_str(";\t y");
        flush_text();
        add_str("'a;");
        flush_text();
        add_str("$a'x;'$");
        flush_text();
        add_str("$t$;$t$;y");
        flush_text();
        add_str("/*/z;*/w");
        flush_text();
        add_str("$q/*$*/$;$q/*$*/$;");
        flush_text();
        add_str("--c;\nw;\"d;\"-");
        flush_text();
        n_directed = texts;
        while (text_words.size() < 2000) begin
            add_random_text();
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        while (text_words.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (stmt_words_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);

        $display("Run covered %0d text words in %0d texts (%0d directed) and %0d output stalls.",
                 words_in, texts, n_directed, holds);
        $display("Checked %0d statement words, %0d statement ends, %0d with tag overflow.",
                 words_out, stmt_ends, ovf_words);
        if (errors == 0) begin
            $display("** sql_statement_splitter: PASSED **");
        end else begin
            $display("** sql_statement_splitter: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sqlss_pkg.sv
design/sqlss_core.sv
design/sqlss_outbuf.sv
design/sql_statement_splitter.sv
sim/sql_statement_splitter_tb.sv
